// ===== src/bm3_pkg.sv =====
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared types, constants and the 3x3 neighborhood evaluation for the
// binary morphology core.
// ----------------------------------------------------------------------------
package bm3_pkg;

  // Default size limits
  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_MAX_HEIGHT = 1024;

  // Register file
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int CFG_DIM_W  = 11;
  localparam int MIN_DIM    = 3;

  localparam logic                 RST_MODE    = 1'b0;
  localparam logic [7:0]           RST_SE_MASK = 8'hFF;
  localparam logic [CFG_DIM_W-1:0] RST_WIDTH   = 11'd320;
  localparam logic [CFG_DIM_W-1:0] RST_HEIGHT  = 11'd240;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_SE_MASK = 2'd1,
    REG_WIDTH   = 2'd2,
    REG_HEIGHT  = 2'd3
  } bm3_reg_e;

  localparam logic MODE_ERODE = 1'b1;

  // Top-left, left and bottom-left neighbor bits
  localparam logic [7:0] LEFT_COL_MASK = 8'h94;

  // Stream widths
  localparam int TDATA_W = 8;

  // History word: bit j holds the pixel j places before the word's own pixel
  localparam int ENTRY_W = 4;

  // Result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = 3;

  typedef struct packed {
    logic       mode;
    logic [7:0] se_mask;
    logic       hold;     // frame size product not yet settled
  } bm3_ctrl_t;

  typedef struct packed {
    logic pixel;
    logic last;
  } bm3_result_t;

  typedef struct packed {
    logic        valid0;
    bm3_result_t res0;
    logic        valid1;
    bm3_result_t res1;
  } bm3_push_t;

  typedef struct packed {
    logic               px;
    logic               r1;
    logic               r2;
    logic               emit;     // regular center result
    logic               last;     // final center of the frame
    logic               first_a;  // first-center rule for the regular result
    logic               first_b;  // first-center rule for the final result
    logic [ENTRY_W-1:0] vmid;     // history bits that were ever written
    logic [ENTRY_W-1:0] vtop;
  } bm3_stage_t;

  // Dilation or erosion of one center over the masked neighbors
  function automatic logic bm3_eval(input logic [7:0] nb, input logic center,
                                    input logic [7:0] mask, input logic mode,
                                    input logic first);
    logic [7:0] m;
    logic       r;
    m = first ? (mask & ~LEFT_COL_MASK) : mask;
    if (mode == MODE_ERODE) begin
      r = center && ((nb & m) == m);
    end else begin
      r = center || (|(nb & m));
    end
    return r;
  endfunction

endpackage

// ===== src/bm3_ram.sv =====
// ----------------------------------------------------------------------------
// bm3_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bm3_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data only updates on enable
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== src/bm3_cfg.sv =====
// ----------------------------------------------------------------------------
// bm3_cfg
// APB register file, size clamping and the registered frame size product.
// ----------------------------------------------------------------------------
module bm3_cfg import bm3_pkg::*; #(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [APB_ADDR_W-1:0]                  paddr,
  input  logic [APB_DATA_W-1:0]                  pwdata,
  output logic [APB_DATA_W-1:0]                  prdata,
  output logic                                   pready,
  output bm3_ctrl_t                              ctrl_o,
  output logic [$clog2(MAX_WIDTH+1)-1:0]         width_o,
  output logic [$clog2(MAX_WIDTH+1)+$clog2(MAX_HEIGHT+1)-1:0] frame_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int FW = WW + HW;

  logic                 mode_q, mode_d;
  logic [7:0]           se_mask_q, se_mask_d;
  logic [CFG_DIM_W-1:0] width_q, width_d;
  logic [CFG_DIM_W-1:0] height_q, height_d;
  logic                 hold_q;
  logic [FW-1:0]        frame_q;
  logic                 wr_en;
  bm3_reg_e             reg_sel;
  logic [WW-1:0]        w_c;
  logic [HW-1:0]        h_c;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = bm3_reg_e'(paddr[3:2]);

  // Register writes
  always_comb begin
    mode_d    = mode_q;
    se_mask_d = se_mask_q;
    width_d   = width_q;
    height_d  = height_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_MODE:    mode_d    = pwdata[0];
        REG_SE_MASK: se_mask_d = pwdata[7:0];
        REG_WIDTH:   width_d   = pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT:  height_d  = pwdata[CFG_DIM_W-1:0];
        default:     mode_d    = mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= RST_MODE;
      se_mask_q <= RST_SE_MASK;
      width_q   <= RST_WIDTH;
      height_q  <= RST_HEIGHT;
    end else begin
      mode_q    <= mode_d;
      se_mask_q <= se_mask_d;
      width_q   <= width_d;
      height_q  <= height_d;
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_sel)
      REG_MODE:    prdata = APB_DATA_W'(mode_q);
      REG_SE_MASK: prdata = APB_DATA_W'(se_mask_q);
      REG_WIDTH:   prdata = APB_DATA_W'(width_q);
      REG_HEIGHT:  prdata = APB_DATA_W'(height_q);
      default:     prdata = '0;
    endcase
  end

  // Saturate sizes to the supported range
  always_comb begin
    if (width_q < CFG_DIM_W'(MIN_DIM)) begin
      w_c = WW'(MIN_DIM);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(width_q);
    end
    if (height_q < CFG_DIM_W'(MIN_DIM)) begin
      h_c = HW'(MIN_DIM);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_c = HW'(MAX_HEIGHT);
    end else begin
      h_c = HW'(height_q);
    end
  end

  // Frame size product, registered, so it follows the size registers in the next cycle
  always_ff @(posedge clk_i) begin
    frame_q <= FW'(w_c) * FW'(h_c);
  end

  // Hold the stream after reset and in the cycle after any write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b1;
    end else begin
      hold_q <= wr_en;
    end
  end

  assign ctrl_o.mode    = mode_q;
  assign ctrl_o.se_mask = se_mask_q;
  assign ctrl_o.hold    = hold_q;
  assign width_o        = w_c;
  assign frame_o        = frame_q;

endmodule

// ===== src/bm3_window.sv =====
// ----------------------------------------------------------------------------
// bm3_window
// Raster position tracking, pixel history RAM and the 3x3 evaluation stage.
// ----------------------------------------------------------------------------
module bm3_window import bm3_pkg::*; #(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bm3_ctrl_t                              ctrl_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]         width_i,
  input  logic [$clog2(MAX_WIDTH+1)+$clog2(MAX_HEIGHT+1)-1:0] frame_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   in_pixel_i,
  input  logic                                   in_start_i,
  input  logic [OUT_CNT_W-1:0]                   free_i,
  output bm3_push_t                              push_o
);

  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int HW       = $clog2(MAX_HEIGHT + 1);
  localparam int FW       = WW + HW;
  localparam int AW       = $clog2(2 * MAX_WIDTH);
  localparam int DEPTH    = 2 ** AW;
  localparam int FILLW    = $clog2(2 * MAX_WIDTH + 4);
  localparam int CW       = FILLW + 1;
  localparam int FILL_SAT = 2 * MAX_WIDTH + 3;

  logic [FW-1:0]      cnt_q, cnt_d;
  logic               first_q, first_d;
  logic [AW-1:0]      wp_q;
  logic [FILLW-1:0]   fill_q;
  logic               r1_q, r2_q, r3_q;
  logic               s1_valid_q, s1_valid_d;
  bm3_stage_t         s1_q, s1_d;

  logic               accept;
  logic               restart;
  logic [FW-1:0]      p;
  logic               first0;
  logic               emit0;
  logic               last0;
  logic [AW-1:0]      raddr_mid, raddr_top;
  logic [ENTRY_W-1:0] rdata_mid, rdata_top;
  logic [ENTRY_W-1:0] vmid, vtop;
  logic [1:0]         n_res;
  logic               s1_adv;
  logic [ENTRY_W-1:0] mid, top;
  logic [7:0]         nb_a, nb_b;
  logic               res_a, res_b;

  // Stage 0 handshake
  assign n_res      = {1'b0, s1_q.emit} + {1'b0, s1_q.last};
  assign s1_adv     = s1_valid_q && (free_i >= OUT_CNT_W'(n_res));
  assign in_ready_o = !ctrl_i.hold && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;

  // Raster position of the incoming pixel
  always_comb begin
    restart = in_start_i || (cnt_q >= frame_i);
    p       = restart ? '0 : cnt_q;
    first0  = restart || first_q;
    emit0   = {1'b0, p} >= ((FW+1)'({width_i, 1'b0}) + (FW+1)'(1));
    last0   = ({1'b0, p} + (FW+1)'(1)) >= {1'b0, frame_i};
    cnt_d   = cnt_q;
    first_d = first_q;
    if (accept) begin
      cnt_d   = last0 ? '0 : p + FW'(1);
      first_d = last0 ? 1'b1 : (emit0 ? 1'b0 : first0);
    end
  end

  // History reads: one row up and two rows up, one pixel ahead
  assign raddr_mid = wp_q + AW'(1) - AW'(width_i);
  assign raddr_top = wp_q + AW'(1) - AW'({width_i, 1'b0});

  // Bits older than the first pixel since reset read as zero
  always_comb begin
    for (int j = 0; j < ENTRY_W; j++) begin
      vmid[j] = (CW'(fill_q) + CW'(1)) >= (CW'(width_i) + CW'(j));
      vtop[j] = (CW'(fill_q) + CW'(1)) >= (CW'({width_i, 1'b0}) + CW'(j));
    end
  end

  bm3_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i ({r3_q, r2_q, r1_q, in_pixel_i}),
    .re_i    (accept),
    .raddr0_i(raddr_mid),
    .raddr1_i(raddr_top),
    .rdata0_o(rdata_mid),
    .rdata1_o(rdata_top)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      first_q    <= 1'b1;
      wp_q       <= '0;
      fill_q     <= '0;
      r1_q       <= 1'b0;
      r2_q       <= 1'b0;
      r3_q       <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      first_q    <= first_d;
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        wp_q <= wp_q + AW'(1);
        r1_q <= in_pixel_i;
        r2_q <= r1_q;
        r3_q <= r2_q;
        if (fill_q != FILLW'(FILL_SAT)) begin
          fill_q <= fill_q + FILLW'(1);
        end
      end
    end
  end

  // Stage 1 capture
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    s1_d         = s1_q;
    if (accept) begin
      s1_d.px      = in_pixel_i;
      s1_d.r1      = r1_q;
      s1_d.r2      = r2_q;
      s1_d.emit    = emit0;
      s1_d.last    = last0;
      s1_d.first_a = first0;
      s1_d.first_b = emit0 ? 1'b0 : first0;
      s1_d.vmid    = vmid;
      s1_d.vtop    = vtop;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // Stage 1 evaluation: regular center and the frame's final center
  always_comb begin
    mid   = rdata_mid & s1_q.vmid;
    top   = rdata_top & s1_q.vtop;
    nb_a  = {top[3], top[2], top[1], mid[3], mid[1], s1_q.r2, s1_q.r1, s1_q.px};
    nb_b  = {top[2], top[1], top[0], mid[2], mid[0], s1_q.r1, s1_q.px, 1'b0};
    res_a = bm3_eval(nb_a, mid[2], ctrl_i.se_mask, ctrl_i.mode, s1_q.first_a);
    res_b = bm3_eval(nb_b, mid[1], ctrl_i.se_mask, ctrl_i.mode, s1_q.first_b);
  end

  always_comb begin
    push_o.valid0     = s1_adv && (s1_q.emit || s1_q.last);
    push_o.res0.pixel = s1_q.emit ? res_a : res_b;
    push_o.res0.last  = !s1_q.emit;
    push_o.valid1     = s1_adv && s1_q.emit && s1_q.last;
    push_o.res1.pixel = res_b;
    push_o.res1.last  = 1'b1;
  end

  // The history reads never hit the entry written in the same cycle
  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (raddr_mid != wp_q) && (raddr_top != wp_q))
    else $error("history read collides with write");

  // A frame end always comes with a regular center result
  a_last_has_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_q.last |-> s1_q.emit)
    else $error("frame end without regular result");

endmodule

// ===== src/bm3_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bm3_out_fifo
// Small result queue: up to two results in per cycle, one out.
// ----------------------------------------------------------------------------
module bm3_out_fifo import bm3_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bm3_push_t            push_i,
  output logic [OUT_CNT_W-1:0] free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bm3_result_t          out_res_o
);

  localparam int PW = $clog2(OUT_DEPTH);

  bm3_result_t          mem_q [OUT_DEPTH];
  logic [PW-1:0]        wr_q, rd_q;
  logic [OUT_CNT_W-1:0] count_q, count_d;
  logic [1:0]           n_push;
  logic                 pop;

  assign n_push      = {1'b0, push_i.valid0} + {1'b0, push_i.valid1};
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign count_d     = count_q + OUT_CNT_W'(n_push) - OUT_CNT_W'(pop);
  assign free_o      = OUT_CNT_W'(OUT_DEPTH) - count_q;
  assign out_res_o   = mem_q[rd_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PW'(n_push);
      rd_q    <= rd_q + PW'(pop);
      count_q <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.valid1) begin
      mem_q[wr_q + PW'(1)] <= push_i.res1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue overflow");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid1 |-> push_i.valid0 && (count_q <= OUT_CNT_W'(OUT_DEPTH - 2)))
    else $error("paired result pushed without room");

endmodule

// ===== src/binary_morphology_3x3_core.sv =====
// ----------------------------------------------------------------------------
// binary_morphology_3x3_core
// 3x3 binary dilation / erosion over a raster pixel stream.
// ----------------------------------------------------------------------------
// The core takes one binary pixel per clock while the output queue has room.
// Each accepted pixel is written to a history RAM of 2**clog2(2*MAX_WIDTH)
// words of 4 bits, read at two addresses (one and two rows back) in the same
// cycle; the result for the center completed by a pixel is evaluated in
// stage 1 and pushed into the output queue. The last pixel of a frame
// produces two results, and the final one carries tlast. The input pauses
// after reset and in the cycle after any register write, while the frame
// size product is registered. There is no clearing pass: a fill counter
// makes history older than reset read as 0. Registers are to be written
// only while the stream is idle; the core does not enforce this.
// ----------------------------------------------------------------------------
module binary_morphology_3x3_core import bm3_pkg::*; #(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Pixel input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // [0] pixel_in, [7:1] zero
  input  logic                  s_axis_tuser,   // [0] frame_start
  // Result output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [0] pixel_out, [7:1] zero
  output logic                  m_axis_tlast,   // frame_last
  // Register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int FW = WW + $clog2(MAX_HEIGHT + 1);

  bm3_ctrl_t            ctrl;
  logic [WW-1:0]        width;
  logic [FW-1:0]        frame;
  bm3_push_t            push;
  logic [OUT_CNT_W-1:0] free;
  bm3_result_t          out_res;

  bm3_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .ctrl_o (ctrl),
    .width_o(width),
    .frame_o(frame)
  );

  bm3_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .width_i   (width),
    .frame_i   (frame),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_pixel_i(s_axis_tdata[0]),
    .in_start_i(s_axis_tuser),
    .free_i    (free),
    .push_o    (push)
  );

  bm3_out_fifo u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .free_o     (free),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (out_res)
  );

  assign m_axis_tdata = {{(TDATA_W-1){1'b0}}, out_res.pixel};
  assign m_axis_tlast = out_res.last;

endmodule
